// ----- design/assert_macros.svh -----
// Assertion macros shared by the inverter efficiency design.
// No dependencies; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define IEM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define IEM_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IEM_ASSERT(lbl, clk, rstn, prop, msg)
`define IEM_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ----- design/iem_pkg.sv -----
// Shared types and constants of the inverter efficiency pipeline.
// No dependencies.
`timescale 1ns / 1ps
package iem_pkg;

    localparam int PDC_W  = 27;
    localparam int VDC_W  = 15;
    localparam int AC_W   = 28;
    localparam int PAR_W  = 16;
    localparam int PLR_W  = 17;
    localparam int EFF_W  = 16;
    localparam int RAC_W  = 26;
    localparam int RDP_W  = 26;
    localparam int RDV_W  = 15;
    localparam int SCP_W  = 20;
    localparam int CC_W   = 32;
    localparam int VC_W   = 36;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 36;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 80;

    localparam int D_W    = 35;
    localparam int P_W    = 31;
    localparam int CS_W   = 41;
    localparam int Q1_W   = 42;
    localparam int PD_W   = 36;
    localparam int QUAD_W = 42;
    localparam int NUM_W  = 56;
    localparam int LIN_QW = 42;
    localparam int RAT_QW = 17;

    localparam int NIGHT_TARE_DEFAULT = 16;

    typedef enum logic [CFG_AW-1:0] {
        CFG_RATED_AC     = 3'd0,
        CFG_RATED_DC     = 3'd1,
        CFG_RATED_VOLT   = 3'd2,
        CFG_SELF_CONS    = 3'd3,
        CFG_CURV         = 3'd4,
        CFG_RATED_PWR_VC = 3'd5,
        CFG_THRESH_VC    = 3'd6,
        CFG_CURV_VC      = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [RAC_W-1:0] rac;
        logic [RDP_W-1:0] rdp;
        logic [RDV_W-1:0] rdv;
        logic [SCP_W-1:0] scp;
        logic [CC_W-1:0]  cc;
        logic [VC_W-1:0]  rpvc;
        logic [VC_W-1:0]  tpvc;
        logic [VC_W-1:0]  cvc;
    } t_cfg;

    // corrected terms, signed fields held as raw bits
    typedef struct packed {
        logic             v;
        logic             below;
        logic [PDC_W-1:0] pdc;
        logic [D_W-1:0]   d;
        logic [P_W-1:0]   p;
        logic [CS_W-1:0]  cs;
    } t_terms;

    // sideband carried through the linear-term divider
    typedef struct packed {
        logic              qneg;
        logic              dz;
        logic              below;
        logic [QUAD_W-1:0] quad;
        logic [PDC_W-1:0]  pdc;
    } t_lin_pl;

    typedef struct packed {
        logic             v;
        logic [NUM_W-1:0] num;
        logic [D_W-1:0]   den;
        t_lin_pl          pl;
    } t_curve;

endpackage

// ----- design/iem_terms.sv -----
// Voltage correction of rated DC power, threshold and curvature (4 stages).
// Depends on iem_pkg.
`timescale 1ns / 1ps
module iem_terms (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [iem_pkg::PDC_W-1:0]   i_pdc,
    input  logic [iem_pkg::VDC_W-1:0]   i_vdc,
    input  iem_pkg::t_cfg               i_cfg,
    output iem_pkg::t_terms             o_terms
);

    logic signed [15:0] dv;
    logic signed [51:0] n_ta, n_tb, n_tc;
    logic                r1_v, r1_below;
    logic [iem_pkg::PDC_W-1:0] r1_pdc;
    logic signed [51:0] r1_ta, r1_tb, r1_tc;

    logic signed [51:0] sa, sb, sc;
    logic                r2_v, r2_below;
    logic [iem_pkg::PDC_W-1:0] r2_pdc;
    logic signed [38:0] r2_fa, r2_fb;
    logic signed [28:0] r2_fc;

    logic signed [65:0] n_pa;
    logic signed [59:0] n_pb;
    logic signed [60:0] n_pc;
    logic                r3_v, r3_below;
    logic [iem_pkg::PDC_W-1:0] r3_pdc;
    logic signed [65:0] r3_pa;
    logic signed [59:0] r3_pb;
    logic signed [60:0] r3_pc;

    logic signed [65:0] sh_a;
    logic signed [59:0] sh_b;
    logic signed [60:0] sh_c;
    iem_pkg::t_terms    n_t4;
    iem_pkg::t_terms    r4;

    assign dv   = $signed({1'b0, i_vdc}) - $signed({1'b0, i_cfg.rdv});
    assign n_ta = $signed(i_cfg.rpvc) * dv;
    assign n_tb = $signed(i_cfg.tpvc) * dv;
    assign n_tc = $signed(i_cfg.cvc) * dv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4.v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4.v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pdc   <= i_pdc;
            r1_below <= (i_pdc <= iem_pkg::PDC_W'(i_cfg.scp));
            r1_ta    <= n_ta;
            r1_tb    <= n_tb;
            r1_tc    <= n_tc;
        end
    end

    assign sa = (r1_ta >>> 14) + 52'sd1073741824;
    assign sb = (r1_tb >>> 14) + 52'sd1073741824;
    assign sc = (r1_tc >>> 24) + 52'sd1048576;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_pdc   <= r1_pdc;
            r2_below <= r1_below;
            r2_fa    <= sa[38:0];
            r2_fb    <= sb[38:0];
            r2_fc    <= sc[28:0];
        end
    end

    assign n_pa = $signed({1'b0, i_cfg.rdp}) * r2_fa;
    assign n_pb = $signed({1'b0, i_cfg.scp}) * r2_fb;
    assign n_pc = $signed(i_cfg.cc) * r2_fc;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_pdc   <= r2_pdc;
            r3_below <= r2_below;
            r3_pa    <= n_pa;
            r3_pb    <= n_pb;
            r3_pc    <= n_pc;
        end
    end

    assign sh_a = r3_pa >>> 30;
    assign sh_b = r3_pb >>> 30;
    assign sh_c = r3_pc >>> 20;

    always_comb begin
        n_t4       = r4;
        n_t4.below = r3_below;
        n_t4.pdc   = r3_pdc;
        n_t4.d     = $signed(sh_a[34:0]) - $signed(sh_b[34:0]);
        n_t4.p     = $signed({4'b0, r3_pdc}) - $signed(sh_b[30:0]);
        n_t4.cs    = sh_c[40:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4.below <= n_t4.below;
            r4.pdc   <= n_t4.pdc;
            r4.d     <= n_t4.d;
            r4.p     <= n_t4.p;
            r4.cs    <= n_t4.cs;
        end
    end

    assign o_terms = r4;

endmodule

// ----- design/iem_curve.sv -----
// Quadratic term with saturation and divider operands (4 stages).
// Depends on iem_pkg.
`timescale 1ns / 1ps
module iem_curve (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  iem_pkg::t_terms    i_t,
    input  iem_pkg::t_cfg      i_cfg,
    output iem_pkg::t_curve    o_c
);

    localparam logic signed [71:0] SAT72 = 72'sd4611686018427387904;
    localparam logic signed [77:0] SAT78 = 78'sd4611686018427387904;

    // stage 5
    logic signed [57:0] n_n;
    logic signed [57:0] n_m1;
    logic signed [55:0] n_m2;
    logic signed [35:0] pe, de;
    logic                r5_v, r5_below, r5_dz;
    logic [iem_pkg::PDC_W-1:0] r5_pdc;
    logic signed [57:0] r5_n, r5_m1;
    logic signed [55:0] r5_m2;
    logic signed [35:0] r5_pd;
    logic signed [34:0] r5_d;

    // stage 6
    logic signed [71:0] e1, e2, csp, csat, q1s;
    logic signed [57:0] negn;
    logic signed [34:0] negd;
    logic                r6_v, r6_below, r6_dz, r6_qneg;
    logic [iem_pkg::PDC_W-1:0] r6_pdc;
    logic [iem_pkg::NUM_W-1:0] r6_num;
    logic [iem_pkg::D_W-1:0]   r6_den;
    logic signed [41:0] r6_q1;
    logic signed [35:0] r6_pd;

    // stage 7
    logic signed [60:0] n_m3;
    logic signed [59:0] n_m4;
    logic                r7_v, r7_below, r7_dz, r7_qneg;
    logic [iem_pkg::PDC_W-1:0] r7_pdc;
    logic [iem_pkg::NUM_W-1:0] r7_num;
    logic [iem_pkg::D_W-1:0]   r7_den;
    logic signed [60:0] r7_m3;
    logic signed [59:0] r7_m4;

    // stage 8
    logic signed [77:0] e3, e4, qp, qsat, qs;
    iem_pkg::t_curve    r8;

    assign pe   = $signed(i_t.p);
    assign de   = $signed(i_t.d);
    assign n_n  = $signed({1'b0, i_cfg.rac}) * $signed(i_t.p);
    assign n_m1 = $signed(i_t.cs) * $signed({1'b0, i_t.p[15:0]});
    assign n_m2 = $signed(i_t.cs) * $signed(i_t.p[30:16]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8.v <= 1'b0;
        end else if (i_en) begin
            r5_v <= i_t.v;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r8.v <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_below <= i_t.below;
            r5_dz    <= (i_t.d == '0);
            r5_pdc   <= i_t.pdc;
            r5_n     <= n_n;
            r5_m1    <= n_m1;
            r5_m2    <= n_m2;
            r5_pd    <= pe - de;
            r5_d     <= $signed(i_t.d);
        end
    end

    assign e1   = r5_m1;
    assign e2   = r5_m2;
    assign csp  = (e2 <<< 16) + e1;
    assign csat = (csp > SAT72) ? SAT72 : ((csp < -SAT72) ? -SAT72 : csp);
    assign q1s  = csat >>> 22;
    assign negn = -r5_n;
    assign negd = -r5_d;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_below <= r5_below;
            r6_dz    <= r5_dz;
            r6_pdc   <= r5_pdc;
            r6_qneg  <= r5_n[57] ^ r5_d[34];
            r6_num   <= r5_n[57] ? negn[55:0] : r5_n[55:0];
            r6_den   <= r5_d[34] ? negd : r5_d;
            r6_q1    <= q1s[41:0];
            r6_pd    <= r5_pd;
        end
    end

    assign n_m3 = r6_q1 * $signed({1'b0, r6_pd[17:0]});
    assign n_m4 = r6_q1 * $signed(r6_pd[35:18]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_below <= r6_below;
            r7_dz    <= r6_dz;
            r7_pdc   <= r6_pdc;
            r7_qneg  <= r6_qneg;
            r7_num   <= r6_num;
            r7_den   <= r6_den;
            r7_m3    <= n_m3;
            r7_m4    <= n_m4;
        end
    end

    assign e3   = r7_m3;
    assign e4   = r7_m4;
    assign qp   = (e4 <<< 18) + e3;
    assign qsat = (qp > SAT78) ? SAT78 : ((qp < -SAT78) ? -SAT78 : qp);
    assign qs   = qsat >>> 22;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r8.num      <= r7_num;
            r8.den      <= r7_den;
            r8.pl.qneg  <= r7_qneg;
            r8.pl.dz    <= r7_dz;
            r8.pl.below <= r7_below;
            r8.pl.quad  <= qs[41:0];
            r8.pl.pdc   <= r7_pdc;
        end
    end

    assign o_c = r8;

endmodule

// ----- design/iem_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module iem_div #(
    parameter int NW = 43,
    parameter int DW = 26,
    parameter int QW = 17,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_pl,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic          o_ovf,
    output logic [PW-1:0] o_pl
);

    localparam int CW = NW + DW;

    logic          r_v   [QW+1];
    logic          r_ovf [QW+1];
    logic [DW-1:0] r_rem [QW+1];
    logic [QW-1:0] r_lq  [QW+1];
    logic [DW-1:0] r_den [QW+1];
    logic [PW-1:0] r_pl  [QW+1];
    logic          n_ovf;

    // quotient would not fit in QW bits
    assign n_ovf = CW'(i_num) >= (CW'(i_den) << QW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= n_ovf;
            r_rem[0] <= DW'(i_num >> QW);
            r_lq[0]  <= i_num[QW-1:0];
            r_den[0] <= i_den;
            r_pl[0]  <= i_pl;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW:0]   t;
        logic [DW:0]   diff;
        logic          ge;

        assign t    = {r_rem[k], r_lq[k][QW-1]};
        assign diff = t - {1'b0, r_den[k]};
        assign ge   = (t >= {1'b0, r_den[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ovf[k+1] <= r_ovf[k];
                r_rem[k+1] <= ge ? diff[DW-1:0] : t[DW-1:0];
                r_lq[k+1]  <= {r_lq[k][QW-2:0], ge};
                r_den[k+1] <= r_den[k];
                r_pl[k+1]  <= r_pl[k];
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_quo   = r_lq[QW];
    assign o_ovf   = r_ovf[QW];
    assign o_pl    = r_pl[QW];

endmodule

// ----- design/inverter_efficiency_model.sv -----
// Grid inverter efficiency model: top level, config registers, output skid.
// Depends on iem_pkg, iem_terms, iem_curve, iem_div, assert_macros.svh.
//
// Input stream (s side): one request carries DC power and DC voltage.
// Output stream (m side): AC power, parasitic power, part-load ratio and
// efficiency for each request, in request order.
// Config channel: register index and data, always ready; write only while
// no request is in flight.
// Pipeline from input acceptance to o_m_tvalid: 4 correction stages,
// 4 curve stages, 43-stage divider for the linear term, 1 power stage,
// 18-stage ratio dividers, output register.
// Throughput: one request per cycle while the skid register is empty; every
// stage is a register and the dividers resolve one quotient bit per stage.
// Reset clears all valid bits and loads the register defaults.
// When the receiver stalls, the output register holds its result and one
// more result goes to a skid register; only when the skid register is full
// does the whole pipeline freeze and o_s_tready drop.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module inverter_efficiency_model #(
    parameter int NIGHT_TARE_POWER = iem_pkg::NIGHT_TARE_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [26:0] dc_power, [41:27] dc_voltage
    input  logic [iem_pkg::S_TDATA_W-1:0]  i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [27:0] ac_power, [43:28] parasitic_power, [60:44] part_load_ratio,
    // [76:61] efficiency
    output logic [iem_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [iem_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  logic [iem_pkg::CFG_DW-1:0]     i_cfg_data
);

    localparam logic signed [44:0] AC_MAX_E = 45'sd134217727;
    localparam logic signed [44:0] AC_MIN_E = -45'sd134217728;
    localparam logic [15:0]        TARE     = 16'(NIGHT_TARE_POWER);

    iem_pkg::t_cfg    r_cfg;
    iem_pkg::t_terms  terms;
    iem_pkg::t_curve  curve;
    iem_pkg::t_lin_pl lin_pl;
    logic             en;

    logic                      lin_v, lin_ovf;
    logic [iem_pkg::LIN_QW-1:0] lin_q;
    logic [$bits(iem_pkg::t_lin_pl)-1:0] lin_plv;

    logic [42:0]        mag;
    logic signed [43:0] lin;
    logic signed [44:0] lin_e, quad_e, sum, rac_e, n_pace;
    logic               r_pv, r_pbelow;
    logic [iem_pkg::AC_W-1:0]  r_pac;
    logic [iem_pkg::PDC_W-1:0] r_ppdc;

    logic                       eff_v, eff_ovf, plr_v, plr_ovf, plr_below;
    logic [iem_pkg::RAT_QW-1:0] eff_q, plr_q;
    logic [iem_pkg::AC_W:0]     eff_pl;
    logic [iem_pkg::EFF_W-1:0]  eff;
    logic [iem_pkg::PLR_W-1:0]  plr;
    logic [iem_pkg::M_TDATA_W-1:0] res;
    logic                       res_v;

    logic                          r_out_v, r_sk_v;
    logic [iem_pkg::M_TDATA_W-1:0] r_out, r_sk;
    logic                          take;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rac  <= iem_pkg::RAC_W'(1);
            r_cfg.rdp  <= iem_pkg::RDP_W'(1);
            r_cfg.rdv  <= iem_pkg::RDV_W'(1);
            r_cfg.scp  <= '0;
            r_cfg.cc   <= '0;
            r_cfg.rpvc <= '0;
            r_cfg.tpvc <= '0;
            r_cfg.cvc  <= '0;
        end else if (i_cfg_valid) begin
            unique case (iem_pkg::t_cfg_reg'(i_cfg_addr))
                iem_pkg::CFG_RATED_AC:     r_cfg.rac  <= i_cfg_data[iem_pkg::RAC_W-1:0];
                iem_pkg::CFG_RATED_DC:     r_cfg.rdp  <= i_cfg_data[iem_pkg::RDP_W-1:0];
                iem_pkg::CFG_RATED_VOLT:   r_cfg.rdv  <= i_cfg_data[iem_pkg::RDV_W-1:0];
                iem_pkg::CFG_SELF_CONS:    r_cfg.scp  <= i_cfg_data[iem_pkg::SCP_W-1:0];
                iem_pkg::CFG_CURV:         r_cfg.cc   <= i_cfg_data[iem_pkg::CC_W-1:0];
                iem_pkg::CFG_RATED_PWR_VC: r_cfg.rpvc <= i_cfg_data[iem_pkg::VC_W-1:0];
                iem_pkg::CFG_THRESH_VC:    r_cfg.tpvc <= i_cfg_data[iem_pkg::VC_W-1:0];
                iem_pkg::CFG_CURV_VC:      r_cfg.cvc  <= i_cfg_data[iem_pkg::VC_W-1:0];
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign en          = !r_sk_v;
    assign o_s_tready  = en;

    iem_terms u_terms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_tvalid),
        .i_pdc   (i_s_tdata[26:0]),
        .i_vdc   (i_s_tdata[41:27]),
        .i_cfg   (r_cfg),
        .o_terms (terms)
    );

    iem_curve u_curve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_t     (terms),
        .i_cfg   (r_cfg),
        .o_c     (curve)
    );

    iem_div #(
        .NW (iem_pkg::NUM_W),
        .DW (iem_pkg::D_W),
        .QW (iem_pkg::LIN_QW),
        .PW ($bits(iem_pkg::t_lin_pl))
    ) u_div_lin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (curve.v),
        .i_num   (curve.num),
        .i_den   (curve.den),
        .i_pl    (curve.pl),
        .o_valid (lin_v),
        .o_quo   (lin_q),
        .o_ovf   (lin_ovf),
        .o_pl    (lin_plv)
    );

    assign lin_pl = lin_plv;

    // linear plus quadratic term, special cases and caps
    always_comb begin
        mag    = lin_ovf ? (43'd1 << iem_pkg::LIN_QW) : {1'b0, lin_q};
        lin    = lin_pl.qneg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        lin_e  = lin;
        quad_e = $signed(lin_pl.quad);
        sum    = lin_e + quad_e;
        rac_e  = $signed({19'b0, r_cfg.rac});
        n_pace = lin_pl.dz ? rac_e : sum;
        if (lin_pl.below) begin
            n_pace = -$signed({29'b0, TARE});
        end
        if (n_pace > rac_e) begin
            n_pace = rac_e;
        end
        if (n_pace > AC_MAX_E) begin
            n_pace = AC_MAX_E;
        end
        if (n_pace < AC_MIN_E) begin
            n_pace = AC_MIN_E;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (en) begin
            r_pv <= lin_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pac    <= n_pace[iem_pkg::AC_W-1:0];
            r_ppdc   <= lin_pl.pdc;
            r_pbelow <= lin_pl.below;
        end
    end

    iem_div #(
        .NW (42),
        .DW (iem_pkg::PDC_W),
        .QW (iem_pkg::RAT_QW),
        .PW (iem_pkg::AC_W + 1)
    ) u_div_eff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_pv),
        .i_num   ({r_pac[25:0], 16'b0}),
        .i_den   (r_ppdc),
        .i_pl    ({r_pac, (r_ppdc == '0) || r_pac[iem_pkg::AC_W-1] || (r_pac == '0)}),
        .o_valid (eff_v),
        .o_quo   (eff_q),
        .o_ovf   (eff_ovf),
        .o_pl    (eff_pl)
    );

    iem_div #(
        .NW (iem_pkg::PDC_W + 16),
        .DW (iem_pkg::RDP_W),
        .QW (iem_pkg::RAT_QW),
        .PW (1)
    ) u_div_plr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_pv),
        .i_num   ({r_ppdc, 16'b0}),
        .i_den   (r_cfg.rdp),
        .i_pl    (r_pbelow),
        .o_valid (plr_v),
        .o_quo   (plr_q),
        .o_ovf   (plr_ovf),
        .o_pl    (plr_below)
    );

    always_comb begin
        if (eff_pl[0]) begin
            eff = '0;
        end else if (eff_ovf || eff_q[iem_pkg::RAT_QW-1]) begin
            eff = '1;
        end else begin
            eff = eff_q[iem_pkg::EFF_W-1:0];
        end
        plr   = plr_ovf ? '1 : plr_q;
        res   = {3'b0, eff, plr, plr_below ? TARE : 16'd0, eff_pl[iem_pkg::AC_W:1]};
        res_v = eff_v & plr_v;
    end

    // output register with one skid entry
    assign take = r_out_v && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (take) begin
            if (r_sk_v) begin
                r_sk_v <= 1'b0;
            end else begin
                r_out_v <= res_v;
            end
        end else if (!r_out_v) begin
            r_out_v <= res_v;
        end else if (en && res_v) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && r_sk_v) begin
            r_out <= r_sk;
        end else if (take || !r_out_v) begin
            r_out <= res;
        end
        if (!take && r_out_v && en) begin
            r_sk <= res;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out;

    `IEM_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_sk_v |-> r_out_v, "skid full with empty output")
    `IEM_ASSERT(a_tare_pair, i_clk, i_rst_n, (o_m_tvalid && (o_m_tdata[43:28] != 16'd0)) |-> (o_m_tdata[27:0] == -28'(TARE)), "parasitic without tare")
    `IEM_ASSERT(a_eff_pos, i_clk, i_rst_n, (o_m_tvalid && (o_m_tdata[76:61] != 16'd0)) |-> (!o_m_tdata[27] && (o_m_tdata[27:0] != 28'd0)), "efficiency with no AC power")
    `IEM_ASSERT_NR(a_reset_idle, i_clk, !i_rst_n |=> !o_m_tvalid, "output valid after reset")

endmodule

// ----- test/iem_scoreboard.sv -----
// Checker for the inverter efficiency pipeline: tracks register writes, computes
// the expected AC power, parasitic power, part-load ratio and efficiency per request.
// Depends on iem_pkg.
`timescale 1ns / 1ps
module iem_scoreboard (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [iem_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [iem_pkg::M_TDATA_W-1:0] i_m_tdata,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [iem_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  logic [iem_pkg::CFG_DW-1:0]    i_cfg_data,
    output int                            o_fail_cnt,
    output int                            o_pending
);

    localparam longint TARE = iem_pkg::NIGHT_TARE_DEFAULT;
    localparam longint PROD_LIM = 64'sd1 <<< 62;

    typedef struct packed {
        logic [iem_pkg::AC_W-1:0]  ac;
        logic [iem_pkg::PAR_W-1:0] par;
        logic [iem_pkg::PLR_W-1:0] plr;
        logic [iem_pkg::EFF_W-1:0] eff;
    } t_plant_out;

    longint unsigned rated_ac, rated_dc, rated_volt, self_cons;
    longint          curv, rated_pwr_vc, thresh_vc, curv_vc;
    t_plant_out      pending_out[$];

    function automatic longint clip_mul(longint a, longint b);
        longint unsigned ua, ub, prod;
        bit neg;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        if (ua != 0 && ub > PROD_LIM / ua) prod = PROD_LIM;
        else prod = ua * ub;
        return neg ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic t_plant_out plant_response(logic [iem_pkg::PDC_W-1:0] pdc_in,
                                                  logic [iem_pkg::VDC_W-1:0] vdc_in);
        longint pdc, dv, fa, fb, fc, a, b, cs, d, p, pac, q1;
        longint unsigned plr, eff;
        t_plant_out r;
        pdc = pdc_in;
        dv  = longint'(vdc_in) - longint'(rated_volt);
        fa  = (64'sd1 <<< 30) + ((rated_pwr_vc * dv) >>> 14);
        fb  = (64'sd1 <<< 30) + ((thresh_vc * dv) >>> 14);
        fc  = (64'sd1 <<< 20) + ((curv_vc * dv) >>> 24);
        a   = (longint'(rated_dc) * fa) >>> 30;
        b   = (longint'(self_cons) * fb) >>> 30;
        cs  = (curv * fc) >>> 20;
        d   = a - b;
        p   = pdc - b;
        if (d == 0) begin
            pac = rated_ac;
        end else begin
            q1  = clip_mul(cs, p) >>> 22;
            pac = (longint'(rated_ac) * p) / d + (clip_mul(q1, p - d) >>> 22);
        end
        r.par = '0;
        if (pdc <= longint'(self_cons)) begin
            pac   = -TARE;
            r.par = iem_pkg::PAR_W'(TARE);
        end
        if (pac > longint'(rated_ac)) pac = rated_ac;
        if (pac > 134217727) pac = 134217727;
        if (pac < -134217728) pac = -134217728;
        if (rated_dc == 0) begin
            plr = 131071;
        end else begin
            plr = (unsigned'(pdc) << 16) / rated_dc;
            if (plr > 131071) plr = 131071;
        end
        if (pdc == 0 || pac <= 0) begin
            eff = 0;
        end else begin
            eff = (unsigned'(pac) << 16) / unsigned'(pdc);
            if (eff > 65535) eff = 65535;
        end
        r.ac  = pac[iem_pkg::AC_W-1:0];
        r.plr = plr[iem_pkg::PLR_W-1:0];
        r.eff = eff[iem_pkg::EFF_W-1:0];
        return r;
    endfunction

    assign o_pending = pending_out.size();

    always @(posedge i_clk) begin
        t_plant_out got, want;
        if (!i_rst_n) begin
            rated_ac <= 1; rated_dc <= 1; rated_volt <= 1; self_cons <= 0;
            curv <= 0; rated_pwr_vc <= 0; thresh_vc <= 0; curv_vc <= 0;
            pending_out.delete();
            o_fail_cnt <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (iem_pkg::t_cfg_reg'(i_cfg_addr))
                    iem_pkg::CFG_RATED_AC:
                        rated_ac     <= i_cfg_data[iem_pkg::RAC_W-1:0];
                    iem_pkg::CFG_RATED_DC:
                        rated_dc     <= i_cfg_data[iem_pkg::RDP_W-1:0];
                    iem_pkg::CFG_RATED_VOLT:
                        rated_volt   <= i_cfg_data[iem_pkg::RDV_W-1:0];
                    iem_pkg::CFG_SELF_CONS:
                        self_cons    <= i_cfg_data[iem_pkg::SCP_W-1:0];
                    iem_pkg::CFG_CURV:
                        curv         <= longint'($signed(i_cfg_data[iem_pkg::CC_W-1:0]));
                    iem_pkg::CFG_RATED_PWR_VC:
                        rated_pwr_vc <= longint'($signed(i_cfg_data[iem_pkg::VC_W-1:0]));
                    iem_pkg::CFG_THRESH_VC:
                        thresh_vc    <= longint'($signed(i_cfg_data[iem_pkg::VC_W-1:0]));
                    iem_pkg::CFG_CURV_VC:
                        curv_vc      <= longint'($signed(i_cfg_data[iem_pkg::VC_W-1:0]));
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                pending_out.push_back(plant_response(
                    i_s_tdata[iem_pkg::PDC_W-1:0],
                    i_s_tdata[iem_pkg::PDC_W +: iem_pkg::VDC_W]));
            if (i_m_tvalid && i_m_tready) begin
                got.ac  = i_m_tdata[0 +: iem_pkg::AC_W];
                got.par = i_m_tdata[28 +: iem_pkg::PAR_W];
                got.plr = i_m_tdata[44 +: iem_pkg::PLR_W];
                got.eff = i_m_tdata[61 +: iem_pkg::EFF_W];
                if (pending_out.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    want = pending_out.pop_front();
                    if (got.ac !== want.ac)
                        $display("%0t: ac_power expected %0d actual %0d", $time,
                                 $signed(want.ac), $signed(got.ac));
                    if (got.par !== want.par)
                        $display("%0t: parasitic_power expected %0d actual %0d", $time,
                                 want.par, got.par);
                    if (got.plr !== want.plr)
                        $display("%0t: part_load_ratio expected %0d actual %0d", $time,
                                 want.plr, got.plr);
                    if (got.eff !== want.eff)
                        $display("%0t: efficiency expected %0d actual %0d", $time,
                                 want.eff, got.eff);
                    if (got !== want) o_fail_cnt <= o_fail_cnt + 1;
                end
            end
        end
    end
endmodule

// ----- test/tb_inverter_efficiency_model.sv -----
// Testbench top for inverter_efficiency_model: drives requests and register writes
// across several settings and gives the verdict. Depends on iem_pkg, iem_scoreboard, inverter_efficiency_model.
`timescale 1ns / 1ps
module tb_inverter_efficiency_model;

    logic                          i_clk = 0;
    logic                          i_rst_n = 0;
    logic                          s_tvalid = 0;
    logic                          s_tready;
    logic [iem_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 0;
    logic [iem_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          cfg_valid = 0;
    logic                          cfg_ready;
    logic [iem_pkg::CFG_AW-1:0]    cfg_addr = '0;
    logic [iem_pkg::CFG_DW-1:0]    cfg_data = '0;
    int                            fail_cnt, pending;
    bit                            hold_req = 0, calm = 0;
    longint                        cur_scp, cur_rdp, cur_rdv;

    always #5 i_clk = ~i_clk;

    inverter_efficiency_model DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data)
    );

    iem_scoreboard u_scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    function automatic int gap_len();
        if (calm) return 0;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: return 0;
            19:     return $urandom_range(20, 60);
            default: return $urandom_range(1, 4);
        endcase
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                m_tready <= 0;
                repeat (400) @(posedge i_clk);
                hold_req = 0;
            end else begin
                g = gap_len();
                if (g > 0) begin
                    m_tready <= 0;
                    repeat (g) @(posedge i_clk);
                end
                m_tready <= 1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(iem_pkg::t_cfg_reg idx, logic [iem_pkg::CFG_DW-1:0] val);
        cfg_valid <= 1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 0;
        case (idx)
            iem_pkg::CFG_RATED_DC:   cur_rdp = val[iem_pkg::RDP_W-1:0];
            iem_pkg::CFG_RATED_VOLT: cur_rdv = val[iem_pkg::RDV_W-1:0];
            iem_pkg::CFG_SELF_CONS:  cur_scp = val[iem_pkg::SCP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic load_all(longint rac, longint rdp, longint rdv, longint scp,
                            longint cc, longint rpvc, longint tvc, longint cvc);
        write_reg(iem_pkg::CFG_RATED_AC, rac);
        write_reg(iem_pkg::CFG_RATED_DC, rdp);
        write_reg(iem_pkg::CFG_RATED_VOLT, rdv);
        write_reg(iem_pkg::CFG_SELF_CONS, scp);
        write_reg(iem_pkg::CFG_CURV, cc);
        write_reg(iem_pkg::CFG_RATED_PWR_VC, rpvc);
        write_reg(iem_pkg::CFG_THRESH_VC, tvc);
        write_reg(iem_pkg::CFG_CURV_VC, cvc);
    endtask

    function automatic longint volt_slope();
        if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
        return longint'($signed($urandom_range(0, 32'hFFFFFF) << 8)) >>> 8;
    endfunction

    task automatic send(longint pdc, longint vdc);
        int g;
        s_tdata  <= {6'd0, vdc[iem_pkg::VDC_W-1:0], pdc[iem_pkg::PDC_W-1:0]};
        s_tvalid <= 1;
        do @(posedge i_clk); while (!s_tready);
        g = hold_req ? 0 : gap_len();
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_random();
        longint pdc, vdc;
        case ($urandom_range(0, 9))
            0, 1: pdc = $urandom_range(0, cur_scp);
            2, 3, 4, 5, 6: pdc = cur_scp + $urandom_range(0, (cur_rdp * 5) / 4 + 2);
            default: pdc = $urandom_range(0, (1 << iem_pkg::PDC_W) - 1);
        endcase
        if ($urandom_range(0, 2) == 0) vdc = $urandom_range(0, 32767);
        else vdc = cur_rdv + $signed($urandom_range(0, 2000)) - 1000;
        if (vdc < 0) vdc = 0;
        if (vdc > 32767) vdc = 32767;
        if (pdc > (1 << iem_pkg::PDC_W) - 1) pdc = (1 << iem_pkg::PDC_W) - 1;
        send(pdc, vdc);
    endtask

    task automatic flush_sender();
        s_tvalid <= 0;
        @(posedge i_clk);
        drain();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        cur_scp = 0; cur_rdp = 1; cur_rdv = 1;
        @(posedge i_clk);

        // directed: realistic plant
        load_all(5000 * 16, 5200 * 16, 400 * 16, 20 * 16, -2000, 36'h0_0100_0000,
                 36'h0_0400_0000, -36'sd16777216);
        send(0, 6400);
        send(1, 6400);
        send(320, 6400);
        send(321, 6400);
        send(5200 * 16, 6400);
        send(5200 * 16, 0);
        send(5200 * 16, 32767);
        send((1 << iem_pkg::PDC_W) - 1, 6400);
        send((1 << iem_pkg::PDC_W) - 1, 32767);
        send(2000 * 16, 1);
        flush_sender();

        // zero denominator
        load_all(1000, 5000, 100, 5000, 12345, 0, 0, 0);
        send(5001, 100);
        send(5000, 100);
        send(90000, 100);
        flush_sender();

        // zero rated DC power, largest rated AC power
        load_all(67108863, 0, 32767, 0, -1, 0, 0, 0);
        send(0, 0);
        send(1, 32767);
        send((1 << iem_pkg::PDC_W) - 1, 0);
        flush_sender();

        // all registers at their top and bottom extremes
        load_all(67108863, 67108863, 32767, 1048575, 32'h7FFF_FFFF,
                 36'h7_FFFF_FFFF, 36'h7_FFFF_FFFF, 36'h7_FFFF_FFFF);
        send(0, 0);
        send((1 << iem_pkg::PDC_W) - 1, 0);
        send((1 << iem_pkg::PDC_W) - 1, 32767);
        send(1048576, 32767);
        flush_sender();
        load_all(1, 1, 1, 0, 32'h8000_0000, 36'h8_0000_0000, 36'h8_0000_0000,
                 36'h8_0000_0000);
        send(0, 0);
        send(1, 1);
        send((1 << iem_pkg::PDC_W) - 1, 32767);
        send(2, 0);
        flush_sender();

        // random settings
        for (int ph = 0; ph < 10; ph++) begin
            longint rdp;
            rdp = $urandom_range(1, 67108863) >> $urandom_range(0, 16);
            if (rdp == 0) rdp = 1;
            load_all($urandom_range(1, 67108863) >> $urandom_range(0, 12), rdp,
                     $urandom_range(1, 32767),
                     $urandom_range(0, 1048575) >> $urandom_range(0, 12),
                     $urandom, volt_slope(), volt_slope(), volt_slope());
            calm = (ph == 2);
            if (ph == 4) begin
                hold_req = 1;
                repeat (120) send_random();
            end
            for (int k = 0; k < 55; k++) begin
                if (ph == 6 && k == 30) flush_sender();
                send_random();
            end
            flush_sender();
        end
        calm = 0;

        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (fail_cnt == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+design
design/iem_pkg.sv
design/iem_terms.sv
design/iem_curve.sv
design/iem_div.sv
design/inverter_efficiency_model.sv
test/iem_scoreboard.sv
test/tb_inverter_efficiency_model.sv
